FILE: src/gpr_pkg.sv
// Shared types and constants of the GPIO port register block.
// Holds command and status codes, register offsets and item structs.
// No dependencies; every other file uses it through scoped names.
package gpr_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_NOREG = 2'd2
  } status_t;

  // Register selected by offset bits [4:2]
  typedef enum logic [2:0] {
    REG_FUNC   = 3'd0,
    REG_DATA   = 3'd1,
    REG_SET    = 3'd2,
    REG_CLR    = 3'd3,
    REG_DIRSET = 3'd4,
    REG_DIRCLR = 3'd5,
    REG_INEN   = 3'd6,
    REG_MUX    = 3'd7
  } reg_sel_t;

  localparam logic [4:0] OFF_MUX   = 5'd28;
  localparam logic [3:0] SIZE_HALF = 4'd2;
  localparam logic [3:0] SIZE_WORD = 4'd4;
  localparam int unsigned PORT_W   = 16;

  // One input item as held in the input register
  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  offset;
    logic [3:0]  access_size;
    logic [31:0] write_data;
    logic [3:0]  pin;
    logic        level;
  } in_item_t;

  // One result item as held in the result register
  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       read_data;
    logic              drive_valid;
    logic [PORT_W-1:0] drive_enable;
    logic [PORT_W-1:0] drive_level;
    logic              fwd_valid;
    logic [3:0]        fwd_pin;
    logic              fwd_level;
  } out_item_t;

  // Decoded access passed from decoder to register file
  typedef struct packed {
    status_t  status;
    logic     wr;
    logic     rd;
    logic     evt;
    reg_sel_t sel;
  } dec_t;

endpackage

FILE: src/gpr_if.sv
// Valid/ready channel interfaces for the GPIO port register block.
// Depends on gpr_pkg for the port width.
interface gpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [4:0]  offset;
  logic [3:0]  access_size;
  logic [31:0] write_data;
  logic [3:0]  pin;
  logic        level;

  modport source (output valid, cmd, offset, access_size, write_data, pin, level,
                  input ready);
  modport sink (input valid, cmd, offset, access_size, write_data, pin, level,
                output ready);
endinterface

interface gpr_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [31:0]                 read_data;
  logic                        drive_valid;
  logic [gpr_pkg::PORT_W-1:0]  drive_enable;
  logic [gpr_pkg::PORT_W-1:0]  drive_level;
  logic                        fwd_valid;
  logic [3:0]                  fwd_pin;
  logic                        fwd_level;

  modport source (output valid, status, read_data, drive_valid, drive_enable,
                  drive_level, fwd_valid, fwd_pin, fwd_level, input ready);
  modport sink (input valid, status, read_data, drive_valid, drive_enable,
                drive_level, fwd_valid, fwd_pin, fwd_level, output ready);
endinterface

FILE: src/gpio_port_registers_unit.sv
// Top level of the GPIO port register block: input register, decode,
// register file and result register. Depends on gpr_pkg, gpr_if,
// gpr_decode and gpr_regs.
//
//   channel  dir  signals
//   in_ch    in   valid/ready, cmd, offset, access_size, write_data, pin, level
//   out_ch   out  valid/ready, status, read_data, drive_*, fwd_*
//
// An item passes from the input register to the result register. One item
// per cycle is sustained while out_ch.ready stays high.
// Reset (rst_n low, synchronous) clears all port registers and empties both stages.
// A stalled result holds; the input stage still takes an item while it is empty.
module gpio_port_registers_unit #(
  parameter int unsigned PIN_COUNT = 16
) (
  input logic       clk,
  input logic       rst_n,
  gpr_in_if.sink    in_ch,
  gpr_out_if.source out_ch
);

  gpr_pkg::in_item_t  s1_r;
  logic               s1_valid_r;
  gpr_pkg::out_item_t out_r;
  logic               out_valid_r;
  gpr_pkg::dec_t      dec;
  gpr_pkg::out_item_t res;
  logic               s1_adv;
  logic               in_acc;

  // Advance the input stage when the result register is empty or being read
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.cmd         <= in_ch.cmd;
      s1_r.offset      <= in_ch.offset;
      s1_r.access_size <= in_ch.access_size;
      s1_r.write_data  <= in_ch.write_data;
      s1_r.pin         <= in_ch.pin;
      s1_r.level       <= in_ch.level;
    end
  end

  gpr_decode u_decode (
    .item (s1_r),
    .dec  (dec)
  );

  gpr_regs #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_adv),
    .item   (s1_r),
    .dec    (dec),
    .res    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.read_data    = out_r.read_data;
  assign out_ch.drive_valid  = out_r.drive_valid;
  assign out_ch.drive_enable = out_r.drive_enable;
  assign out_ch.drive_level  = out_r.drive_level;
  assign out_ch.fwd_valid    = out_r.fwd_valid;
  assign out_ch.fwd_pin      = out_r.fwd_pin;
  assign out_ch.fwd_level    = out_r.fwd_level;

`ifndef SYNTH
  // A held item stays in the input stage until it advances
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input stage item lost");

  // A failed access returns no data and drives no pins
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != gpr_pkg::ST_OK) |->
      (out_r.read_data == '0) && !out_r.drive_valid)
    else $error("failed access produced output");

  // A result never both drives pins and forwards an event
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.drive_valid && out_r.fwd_valid))
    else $error("drive and forward in one item");

  // Drive levels appear only on driven pins
  a_level_in_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.drive_level & ~out_r.drive_enable) == '0))
    else $error("drive level outside enabled pins");
`endif

endmodule

FILE: src/gpr_decode.sv
// Access decoder: size and alignment check, register select, command split.
// Depends on gpr_pkg.
module gpr_decode (
  input  gpr_pkg::in_item_t item,
  output gpr_pkg::dec_t     dec
);

  gpr_pkg::cmd_t cmd;
  logic          size_ok;
  logic          is_access;
  gpr_pkg::status_t chk;

  assign cmd = gpr_pkg::cmd_t'(item.cmd);

  // Check size first, then word alignment of the register
  always_comb begin
    if (item.offset == gpr_pkg::OFF_MUX) begin
      size_ok = (item.access_size == gpr_pkg::SIZE_WORD);
    end else begin
      size_ok = (item.access_size == gpr_pkg::SIZE_HALF) && !item.offset[0];
    end
    priority if (!size_ok) begin
      chk = gpr_pkg::ST_SIZE;
    end else if (item.offset[1:0] != 2'b00) begin
      chk = gpr_pkg::ST_NOREG;
    end else begin
      chk = gpr_pkg::ST_OK;
    end
  end

  // Split by command; only bus accesses report a status
  always_comb begin
    is_access  = (cmd == gpr_pkg::CMD_WRITE) || (cmd == gpr_pkg::CMD_READ);
    dec.status = is_access ? chk : gpr_pkg::ST_OK;
    dec.wr     = (cmd == gpr_pkg::CMD_WRITE) && (chk == gpr_pkg::ST_OK);
    dec.rd     = (cmd == gpr_pkg::CMD_READ) && (chk == gpr_pkg::ST_OK);
    dec.evt    = (cmd == gpr_pkg::CMD_EVENT);
    dec.sel    = gpr_pkg::reg_sel_t'(item.offset[4:2]);
  end

endmodule

FILE: src/gpr_regs.sv
// Port registers: write update, read mux, drive output and event filter.
// Depends on gpr_pkg; fed by gpr_decode.
module gpr_regs #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  gpr_pkg::in_item_t  item,
  input  gpr_pkg::dec_t      dec,
  output gpr_pkg::out_item_t res
);

  localparam int unsigned W = gpr_pkg::PORT_W;
  localparam logic [4:0] PIN_LIMIT = 5'(PIN_COUNT);

  logic [W-1:0]  func_r, func_nxt;
  logic [W-1:0]  data_r, data_nxt;
  logic [W-1:0]  dir_r, dir_nxt;
  logic [W-1:0]  inen_r, inen_nxt;
  logic [31:0]   mux_r, mux_nxt;
  logic [W-1:0]  low;
  logic [W-1:0]  pin_mask;
  logic [W-1:0]  drv_en;
  logic [W-1:0]  pin_bit;
  logic          drive;
  logic          fwd;
  logic [31:0]   rdata;

  assign low = item.write_data[W-1:0];

  // Pins that exist on this port
  always_comb begin
    for (int i = 0; i < W; i++) begin
      pin_mask[i] = (i < PIN_COUNT);
    end
  end

  // Next register values for a good write
  always_comb begin
    func_nxt = func_r;
    data_nxt = data_r;
    dir_nxt  = dir_r;
    inen_nxt = inen_r;
    mux_nxt  = mux_r;
    drive    = 1'b0;
    if (dec.wr) begin
      unique case (dec.sel)
        gpr_pkg::REG_FUNC:   func_nxt = low;
        gpr_pkg::REG_DATA:   begin data_nxt = low; drive = 1'b1; end
        gpr_pkg::REG_SET:    begin data_nxt = data_r | low; drive = 1'b1; end
        gpr_pkg::REG_CLR:    begin data_nxt = data_r & ~low; drive = 1'b1; end
        gpr_pkg::REG_DIRSET: begin dir_nxt = dir_r | low; drive = 1'b1; end
        gpr_pkg::REG_DIRCLR: dir_nxt = dir_r & ~low;
        gpr_pkg::REG_INEN:   inen_nxt = low;
        gpr_pkg::REG_MUX:    mux_nxt = item.write_data;
        default:             mux_nxt = mux_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    rdata = '0;
    if (dec.rd) begin
      unique case (dec.sel)
        gpr_pkg::REG_FUNC:   rdata = {16'h0, func_r};
        gpr_pkg::REG_DATA,
        gpr_pkg::REG_SET,
        gpr_pkg::REG_CLR:    rdata = {16'h0, data_r};
        gpr_pkg::REG_DIRSET,
        gpr_pkg::REG_DIRCLR: rdata = {16'h0, dir_r};
        gpr_pkg::REG_INEN:   rdata = {16'h0, inen_r};
        gpr_pkg::REG_MUX:    rdata = mux_r;
        default:             rdata = '0;
      endcase
    end
  end

  // Forward a pin event only on an enabled input pin
  always_comb begin
    pin_bit = W'(1) << item.pin;
    fwd = dec.evt && ({1'b0, item.pin} < PIN_LIMIT) && ((dir_r & pin_bit) == '0) &&
          ((inen_r & pin_bit) != '0) && ((func_r & pin_bit) != '0);
  end

  // Assemble result from post-write state
  always_comb begin
    drv_en           = ~inen_nxt & pin_mask;
    res.status       = dec.status;
    res.read_data    = rdata;
    res.drive_valid  = drive;
    res.drive_enable = drive ? drv_en : '0;
    res.drive_level  = drive ? (data_nxt & drv_en) : '0;
    res.fwd_valid    = fwd;
    res.fwd_pin      = fwd ? item.pin : '0;
    res.fwd_level    = fwd & item.level;
  end

  // Commit state as the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r <= '0;
      data_r <= '0;
      dir_r  <= '0;
      inen_r <= '0;
      mux_r  <= '0;
    end else if (commit) begin
      func_r <= func_nxt;
      data_r <= data_nxt;
      dir_r  <= dir_nxt;
      inen_r <= inen_nxt;
      mux_r  <= mux_nxt;
    end
  end

endmodule

FILE: sim/gpio_port_registers_unit_test.sv
// Self-checking testbench for the GPIO port register block.
// Drives register accesses and pin events through the valid/ready channels
// and checks each result against a local port model. Needs gpr_pkg and gpr_if.
module gpio_port_registers_unit_test;

  localparam int unsigned PIN_COUNT = 16;
  localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 1);

  logic clk = 1'b0;
  logic rst_n;

  gpr_in_if  in_ch ();
  gpr_out_if out_ch ();

  gpio_port_registers_unit #(.PIN_COUNT(PIN_COUNT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Port model state
  logic [15:0] func_en;
  logic [15:0] pin_lvl;
  logic [15:0] dir_bits;
  logic [15:0] in_en;
  logic [31:0] mux_sel;

  gpr_pkg::in_item_t  pending_items[$];
  gpr_pkg::out_item_t expected_results[$];
  int                 mismatch_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Size and alignment check first, then the register hole check
  function automatic gpr_pkg::status_t access_status(logic [4:0] off, logic [3:0] size);
    if (off == gpr_pkg::OFF_MUX) begin
      if (size != gpr_pkg::SIZE_WORD) return gpr_pkg::ST_SIZE;
    end else if (size != gpr_pkg::SIZE_HALF || off[0]) begin
      return gpr_pkg::ST_SIZE;
    end
    if (off[1:0] != 2'b00) return gpr_pkg::ST_NOREG;
    return gpr_pkg::ST_OK;
  endfunction

  // Apply one item to the port model and return the result it causes
  function automatic gpr_pkg::out_item_t predict_port_result(gpr_pkg::in_item_t it);
    gpr_pkg::out_item_t res;
    logic [15:0]        half;
    logic [15:0]        bitm;
    logic               drive;
    res   = '0;
    half  = it.write_data[15:0];
    drive = 1'b0;
    case (gpr_pkg::cmd_t'(it.cmd))
      gpr_pkg::CMD_WRITE: begin
        res.status = access_status(it.offset, it.access_size);
        if (res.status == gpr_pkg::ST_OK) begin
          case (gpr_pkg::reg_sel_t'(it.offset[4:2]))
            gpr_pkg::REG_FUNC:   func_en = half;
            gpr_pkg::REG_DATA:   begin pin_lvl = half; drive = 1'b1; end
            gpr_pkg::REG_SET:    begin pin_lvl = pin_lvl | half; drive = 1'b1; end
            gpr_pkg::REG_CLR:    begin pin_lvl = pin_lvl & ~half; drive = 1'b1; end
            gpr_pkg::REG_DIRSET: begin dir_bits = dir_bits | half; drive = 1'b1; end
            gpr_pkg::REG_DIRCLR: dir_bits = dir_bits & ~half;
            gpr_pkg::REG_INEN:   in_en = half;
            default:             mux_sel = it.write_data;
          endcase
        end
      end
      gpr_pkg::CMD_READ: begin
        res.status = access_status(it.offset, it.access_size);
        if (res.status == gpr_pkg::ST_OK) begin
          case (gpr_pkg::reg_sel_t'(it.offset[4:2]))
            gpr_pkg::REG_FUNC:   res.read_data = {16'd0, func_en};
            gpr_pkg::REG_DATA,
            gpr_pkg::REG_SET,
            gpr_pkg::REG_CLR:    res.read_data = {16'd0, pin_lvl};
            gpr_pkg::REG_DIRSET,
            gpr_pkg::REG_DIRCLR: res.read_data = {16'd0, dir_bits};
            gpr_pkg::REG_INEN:   res.read_data = {16'd0, in_en};
            default:             res.read_data = mux_sel;
          endcase
        end
      end
      gpr_pkg::CMD_EVENT: begin
        // Forward only on an enabled input pin
        if (int'(it.pin) < PIN_COUNT) begin
          bitm = 16'd1 << it.pin;
          if ((dir_bits & bitm) == 16'd0 && (in_en & bitm) != 16'd0 &&
              (func_en & bitm) != 16'd0) begin
            res.fwd_valid = 1'b1;
            res.fwd_pin   = it.pin;
            res.fwd_level = it.level;
          end
        end
      end
      default: ;
    endcase
    if (drive) begin
      res.drive_valid  = 1'b1;
      res.drive_enable = ~in_en & PIN_MASK;
      res.drive_level  = pin_lvl & res.drive_enable;
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none
  function automatic int idle_length(ref int burst_left);
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_item(gpr_pkg::cmd_t c, logic [4:0] off, logic [3:0] sz,
                                     logic [31:0] wd, logic [3:0] p, logic lv);
    gpr_pkg::in_item_t it;
    it.cmd         = c;
    it.offset      = off;
    it.access_size = sz;
    it.write_data  = wd;
    it.pin         = p;
    it.level       = lv;
    pending_items.push_back(it);
  endfunction

  // Driver: present queued items, hold until accepted, insert random gaps
  gpr_pkg::in_item_t cur_item;
  int                send_gap   = 0;
  int                send_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_port_result(cur_item));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_ch.cmd         <= cur_item.cmd;
          in_ch.offset      <= cur_item.offset;
          in_ch.access_size <= cur_item.access_size;
          in_ch.write_data  <= cur_item.write_data;
          in_ch.pin         <= cur_item.pin;
          in_ch.level       <= cur_item.level;
          in_ch.valid       <= 1'b1;
          send_gap = idle_length(send_burst);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each accepted result with the oldest expectation
  int                 stall_left  = 0;
  int                 stall_burst = 0;
  gpr_pkg::out_item_t got;
  gpr_pkg::out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status       = out_ch.status;
        got.read_data    = out_ch.read_data;
        got.drive_valid  = out_ch.drive_valid;
        got.drive_enable = out_ch.drive_enable;
        got.drive_level  = out_ch.drive_level;
        got.fwd_valid    = out_ch.fwd_valid;
        got.fwd_pin      = out_ch.fwd_pin;
        got.fwd_level    = out_ch.fwd_level;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.read_data !== want.read_data ||
              got.drive_valid !== want.drive_valid ||
              got.drive_enable !== want.drive_enable ||
              got.drive_level !== want.drive_level ||
              got.fwd_valid !== want.fwd_valid || got.fwd_pin !== want.fwd_pin ||
              got.fwd_level !== want.fwd_level) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: result mismatch\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = idle_length(stall_burst);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    gpr_pkg::in_item_t it;
    int                r;
    int                sel;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.offset = '0;
    in_ch.access_size = '0;
    in_ch.write_data = '0;
    in_ch.pin = '0;
    in_ch.level = 1'b0;
    out_ch.ready = 1'b0;
    func_en = '0;
    pin_lvl = '0;
    dir_bits = '0;
    in_en = '0;
    mux_sel = '0;

    // Directed: register extremes, forwarding, blocking and access errors
    queue_item(gpr_pkg::CMD_READ,  gpr_pkg::OFF_MUX, gpr_pkg::SIZE_WORD, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd0,  gpr_pkg::SIZE_HALF, 32'hFFFF_FFFF, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd24, gpr_pkg::SIZE_HALF, 32'h0000_FFFF, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_EVENT, 5'd0,  4'd0, 32'd0, 4'd15, 1'b1);
    queue_item(gpr_pkg::CMD_EVENT, 5'd0,  4'd0, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd4,  gpr_pkg::SIZE_HALF, 32'hA5A5_5AC3, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd24, gpr_pkg::SIZE_HALF, 32'h0000_00FF, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd8,  gpr_pkg::SIZE_HALF, 32'h0000_FFFF, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd12, gpr_pkg::SIZE_HALF, 32'hFFFF_0F0F, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd16, gpr_pkg::SIZE_HALF, 32'h0000_8001, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_EVENT, 5'd0,  4'd0, 32'd0, 4'd0, 1'b1);
    queue_item(gpr_pkg::CMD_WRITE, 5'd20, gpr_pkg::SIZE_HALF, 32'h0000_FFFF, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, gpr_pkg::OFF_MUX, gpr_pkg::SIZE_WORD, 32'hFFFF_FFFF,
               4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  5'd0,  gpr_pkg::SIZE_HALF, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  5'd12, gpr_pkg::SIZE_HALF, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  5'd20, gpr_pkg::SIZE_HALF, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  gpr_pkg::OFF_MUX, gpr_pkg::SIZE_WORD, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, gpr_pkg::OFF_MUX, gpr_pkg::SIZE_HALF, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  5'd4,  gpr_pkg::SIZE_WORD, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd5,  gpr_pkg::SIZE_HALF, 32'h0000_1234, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  5'd29, gpr_pkg::SIZE_WORD, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  5'd2,  gpr_pkg::SIZE_HALF, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_WRITE, 5'd30, gpr_pkg::SIZE_HALF, 32'hFFFF_FFFF, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_READ,  5'd8,  4'd15, 32'd0, 4'd0, 1'b0);
    queue_item(gpr_pkg::CMD_NONE,  5'd31, 4'd15, 32'hFFFF_FFFF, 4'd15, 1'b1);

    // Random: mostly well-formed accesses and pin events, some malformed ones
    repeat (1400) begin
      it.offset      = 5'($urandom_range(0, 31));
      it.access_size = 4'($urandom_range(0, 15));
      it.write_data  = $urandom;
      it.pin         = 4'($urandom_range(0, 15));
      it.level       = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 35)      it.cmd = gpr_pkg::CMD_WRITE;
      else if (r < 65) it.cmd = gpr_pkg::CMD_READ;
      else if (r < 95) it.cmd = gpr_pkg::CMD_EVENT;
      else             it.cmd = gpr_pkg::CMD_NONE;
      if ((it.cmd == gpr_pkg::CMD_WRITE || it.cmd == gpr_pkg::CMD_READ) &&
          $urandom_range(0, 99) < 85) begin
        sel = $urandom_range(0, 7);
        it.offset      = 5'(sel * 4);
        it.access_size = (gpr_pkg::reg_sel_t'(sel) == gpr_pkg::REG_MUX) ?
                         gpr_pkg::SIZE_WORD : gpr_pkg::SIZE_HALF;
      end
      r = $urandom_range(0, 99);
      if (r < 8)       it.write_data = 32'd0;
      else if (r < 16) it.write_data = 32'hFFFF_FFFF;
      pending_items.push_back(it);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then allow the two-stage pipeline to settle
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
src/gpr_pkg.sv
src/gpr_if.sv
src/gpr_decode.sv
src/gpr_regs.sv
src/gpio_port_registers_unit.sv
sim/gpio_port_registers_unit_test.sv
